// ===== rtl/slxf_pkg.sv =====
// shared types and constants for the sync/length/xor frame receiver
package slxf_pkg;

  localparam int unsigned ByteW     = 8;
  localparam int unsigned StatusW   = 3;
  localparam int unsigned CfgIndexW = 2;
  localparam int unsigned QueueDepth = 4;
  localparam int unsigned QueuePtrW  = $clog2(QueueDepth);
  localparam int unsigned QueueCntW  = $clog2(QueueDepth + 1);

  // configuration register indexes
  localparam logic [CfgIndexW-1:0] RegFirstSync  = 2'd0;
  localparam logic [CfgIndexW-1:0] RegSecondSync = 2'd1;
  localparam logic [CfgIndexW-1:0] RegHuntLimit  = 2'd2;

  // reset values of the registers
  localparam logic [ByteW-1:0] FirstSyncReset  = 8'h06;
  localparam logic [ByteW-1:0] SecondSyncReset = 8'h85;
  localparam logic [ByteW-1:0] HuntLimitReset  = 8'd10;

  // frame status codes
  localparam logic [StatusW-1:0] StatusOk        = 3'd0;
  localparam logic [StatusW-1:0] StatusNoStart   = 3'd1;
  localparam logic [StatusW-1:0] StatusBadSync2  = 3'd2;
  localparam logic [StatusW-1:0] StatusZeroLen   = 3'd3;
  localparam logic [StatusW-1:0] StatusBadSum    = 3'd4;

  // result kinds
  localparam logic KindPayload = 1'b0;
  localparam logic KindStatus  = 1'b1;

  typedef struct packed {
    logic               result_kind;
    logic [ByteW-1:0]   payload_byte;
    logic [ByteW-1:0]   byte_index;
    logic [StatusW-1:0] frame_status;
    logic               frame_end;
  } result_t;

endpackage

// ===== rtl/sync_length_xor_frame_receiver_top.sv =====
// top level of the sync/length/xor frame receiver
// a byte's result is registered into the result queue when its request is taken and reaches the result ports in order
// throughput: one byte per cycle, set by the single-step parser; a four-entry
//   result queue lets the consumer stall without stopping input until it fills
// full rises while the result queue is full, since any byte may cause a result
// reset (rst, synchronous) clears the queue, restores register defaults and resumes hunting
module sync_length_xor_frame_receiver_top (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              push,
  output logic                              full,
  input  logic [slxf_pkg::ByteW-1:0]        rx_byte,
  output logic                              empty,
  input  logic                              pop,
  output logic                              result_kind,
  output logic [slxf_pkg::ByteW-1:0]        payload_byte,
  output logic [slxf_pkg::ByteW-1:0]        byte_index,
  output logic [slxf_pkg::StatusW-1:0]      frame_status,
  output logic                              frame_end,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [slxf_pkg::CfgIndexW-1:0]    cfg_index,
  input  logic [slxf_pkg::ByteW-1:0]        cfg_data
);

  logic              step;
  logic              res_valid;
  slxf_pkg::result_t res, head;

  assign cfg_ready = 1'b1;
  assign step      = push && !full;

  slxf_parser u_parser (
    .clk       (clk),
    .rst       (rst),
    .step      (step),
    .rx_byte   (rx_byte),
    .cfg_write (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .res_valid (res_valid),
    .res       (res)
  );

  slxf_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (res_valid),
    .wr_data (res),
    .rd_en   (pop),
    .rd_data (head),
    .full    (full),
    .empty   (empty)
  );

  assign result_kind  = head.result_kind;
  assign payload_byte = head.payload_byte;
  assign byte_index   = head.byte_index;
  assign frame_status = head.frame_status;
  assign frame_end    = head.frame_end;

endmodule

// ===== rtl/slxf_parser.sv =====
// front part: frame parser that turns received bytes into payload and status results
module slxf_parser (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              step,
  input  logic [slxf_pkg::ByteW-1:0]        rx_byte,
  input  logic                              cfg_write,
  input  logic [slxf_pkg::CfgIndexW-1:0]    cfg_index,
  input  logic [slxf_pkg::ByteW-1:0]        cfg_data,
  output logic                              res_valid,
  output slxf_pkg::result_t                 res
);

  typedef enum logic [2:0] {
    PH_HUNT  = 3'd0,
    PH_SYNC2 = 3'd1,
    PH_LEN   = 3'd2,
    PH_DATA  = 3'd3,
    PH_CHECK = 3'd4
  } phase_t;

  phase_t                      phase, phase_next;
  logic [slxf_pkg::ByteW-1:0]  first_sync, second_sync, hunt_limit;
  logic [slxf_pkg::ByteW-1:0]  hunt_remaining, hunt_remaining_next;
  logic [slxf_pkg::ByteW-1:0]  frame_length, frame_length_next;
  logic [slxf_pkg::ByteW-1:0]  payload_count, payload_count_next;
  logic [slxf_pkg::ByteW-1:0]  running_xor, running_xor_next;
  logic [slxf_pkg::ByteW-1:0]  hunt_dec, count_inc;
  logic                        emit_status;
  logic                        hunt_load;
  logic [slxf_pkg::StatusW-1:0] status;

  assign hunt_dec  = hunt_remaining - 8'd1;
  assign count_inc = payload_count + 8'd1;

  always_comb begin
    phase_next          = phase;
    hunt_remaining_next = hunt_remaining;
    frame_length_next   = frame_length;
    payload_count_next  = payload_count;
    running_xor_next    = running_xor;
    emit_status         = 1'b0;
    status              = slxf_pkg::StatusOk;
    res_valid           = 1'b0;
    res.result_kind     = slxf_pkg::KindPayload;
    res.payload_byte    = '0;
    res.byte_index      = '0;
    res.frame_status    = slxf_pkg::StatusOk;
    res.frame_end       = 1'b0;

    unique case (phase)
      PH_SYNC2: begin
        if (rx_byte != second_sync) begin
          emit_status = 1'b1;
          status      = slxf_pkg::StatusBadSync2;
        end else begin
          phase_next = PH_LEN;
        end
      end
      PH_LEN: begin
        if (rx_byte == '0) begin
          emit_status = 1'b1;
          status      = slxf_pkg::StatusZeroLen;
        end else begin
          frame_length_next  = rx_byte;
          running_xor_next   = rx_byte;
          payload_count_next = '0;
          phase_next         = PH_DATA;
        end
      end
      PH_DATA: begin
        res_valid          = 1'b1;
        res.payload_byte   = rx_byte;
        res.byte_index     = payload_count;
        running_xor_next   = running_xor ^ rx_byte;
        payload_count_next = count_inc;
        if (count_inc == frame_length) phase_next = PH_CHECK;
      end
      PH_CHECK: begin
        emit_status = 1'b1;
        status      = (rx_byte == running_xor) ? slxf_pkg::StatusOk
                                               : slxf_pkg::StatusBadSum;
      end
      default: begin
        // unused codes behave as hunting
        if (rx_byte == first_sync) begin
          phase_next = PH_SYNC2;
        end else begin
          phase_next          = PH_HUNT;
          hunt_remaining_next = hunt_dec;
          if (hunt_dec == '0) begin
            emit_status = 1'b1;
            status      = slxf_pkg::StatusNoStart;
          end
        end
      end
    endcase

    if (emit_status) begin
      res_valid           = 1'b1;
      res.result_kind     = slxf_pkg::KindStatus;
      res.payload_byte    = '0;
      res.byte_index      = '0;
      res.frame_status    = status;
      res.frame_end       = 1'b1;
      phase_next          = PH_HUNT;
      hunt_remaining_next = hunt_limit;
    end

    if (!step) res_valid = 1'b0;

    // a new limit takes effect at once while hunting
    hunt_load = step;
    if (cfg_write && cfg_index == slxf_pkg::RegHuntLimit &&
        phase != PH_SYNC2 && phase != PH_LEN && phase != PH_DATA &&
        phase != PH_CHECK) begin
      hunt_remaining_next = cfg_data;
      hunt_load           = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_HUNT;
      first_sync     <= slxf_pkg::FirstSyncReset;
      second_sync    <= slxf_pkg::SecondSyncReset;
      hunt_limit     <= slxf_pkg::HuntLimitReset;
      hunt_remaining <= slxf_pkg::HuntLimitReset;
      frame_length   <= '0;
      payload_count  <= '0;
      running_xor    <= '0;
    end else begin
      if (step) begin
        phase          <= phase_next;
        frame_length   <= frame_length_next;
        payload_count  <= payload_count_next;
        running_xor    <= running_xor_next;
      end
      if (hunt_load) hunt_remaining <= hunt_remaining_next;
      if (cfg_write) begin
        case (cfg_index)
          slxf_pkg::RegFirstSync:  first_sync  <= cfg_data;
          slxf_pkg::RegSecondSync: second_sync <= cfg_data;
          slxf_pkg::RegHuntLimit:  hunt_limit  <= cfg_data;
          default: ;
        endcase
      end
    end
  end

endmodule

// ===== rtl/slxf_queue.sv =====
// back part: short result queue that holds results until the consumer takes them
module slxf_queue (
  input  logic              clk,
  input  logic              rst,
  input  logic              wr_en,
  input  slxf_pkg::result_t wr_data,
  input  logic              rd_en,
  output slxf_pkg::result_t rd_data,
  output logic              full,
  output logic              empty
);

  slxf_pkg::result_t                  mem [slxf_pkg::QueueDepth];
  logic [slxf_pkg::QueuePtrW-1:0]     wr_ptr, rd_ptr;
  logic [slxf_pkg::QueueCntW-1:0]     count;
  logic                               do_wr, do_rd;

  assign full    = (count == slxf_pkg::QueueCntW'(slxf_pkg::QueueDepth));
  assign empty   = (count == '0);
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;
  assign rd_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_wr) mem[wr_ptr] <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) wr_ptr <= wr_ptr + 1'b1;
      if (do_rd) rd_ptr <= rd_ptr + 1'b1;
      case ({do_wr, do_rd})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: ;
      endcase
    end
  end

endmodule

// ===== rtl/slxf_checker.sv =====
// port-level checks on the frame receiver, bound to the top level
module slxf_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          empty,
  input logic                          pop,
  input logic                          result_kind,
  input logic [slxf_pkg::ByteW-1:0]    payload_byte,
  input logic [slxf_pkg::ByteW-1:0]    byte_index,
  input logic [slxf_pkg::StatusW-1:0]  frame_status,
  input logic                          frame_end
);

  a_reset_empty: assert property (@(posedge clk) rst |=> empty)
    else $error("result queue not empty after reset");

  a_end_on_status: assert property (@(posedge clk) disable iff (rst)
    !empty |-> (frame_end == result_kind))
    else $error("frame_end does not match result kind");

  a_status_fields: assert property (@(posedge clk) disable iff (rst)
    (!empty && result_kind) |-> (payload_byte == '0 && byte_index == '0 &&
      (frame_status == slxf_pkg::StatusOk || frame_status == slxf_pkg::StatusNoStart ||
       frame_status == slxf_pkg::StatusBadSync2 ||
       frame_status == slxf_pkg::StatusZeroLen ||
       frame_status == slxf_pkg::StatusBadSum)))
    else $error("bad status result fields");

  a_payload_fields: assert property (@(posedge clk) disable iff (rst)
    (!empty && !result_kind) |-> (frame_status == slxf_pkg::StatusOk))
    else $error("payload result carries a status");

  a_hold_stalled: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> (!empty && $stable(payload_byte) && $stable(byte_index) &&
      $stable(frame_status) && $stable(result_kind)))
    else $error("stalled result changed");

endmodule

bind sync_length_xor_frame_receiver_top slxf_checker u_slxf_checker (
  .clk          (clk),
  .rst          (rst),
  .empty        (empty),
  .pop          (pop),
  .result_kind  (result_kind),
  .payload_byte (payload_byte),
  .byte_index   (byte_index),
  .frame_status (frame_status),
  .frame_end    (frame_end)
);

// ===== tb/tb_sync_length_xor_frame_receiver_top.sv =====
// self-checking testbench for the sync/length/xor frame receiver
`timescale 1ns / 1ps

typedef enum logic [2:0] {
  PhHunt  = 3'd0,
  PhSync2 = 3'd1,
  PhLen   = 3'd2,
  PhData  = 3'd3,
  PhCheck = 3'd4
} parse_phase_t;

class frame_result_book;
  logic [7:0] first_sync;
  logic [7:0] second_sync;
  logic [7:0] hunt_limit;
  parse_phase_t phase;
  logic [7:0] hunt_left;
  logic [7:0] frame_len;
  logic [7:0] payload_cnt;
  logic [7:0] xor_sum;
  slxf_pkg::result_t owed_results[$];
  int errors;
  int payloads_seen;
  int status_seen[8];

  function new();
    first_sync  = slxf_pkg::FirstSyncReset;
    second_sync = slxf_pkg::SecondSyncReset;
    hunt_limit  = slxf_pkg::HuntLimitReset;
    phase       = PhHunt;
    hunt_left   = hunt_limit;
    frame_len   = '0;
    payload_cnt = '0;
    xor_sum     = '0;
    errors      = 0;
    payloads_seen = 0;
    foreach (status_seen[i]) status_seen[i] = 0;
  endfunction

  function void write_reg(logic [slxf_pkg::CfgIndexW-1:0] idx, logic [7:0] data);
    case (idx)
      slxf_pkg::RegFirstSync:  first_sync = data;
      slxf_pkg::RegSecondSync: second_sync = data;
      slxf_pkg::RegHuntLimit: begin
        hunt_limit = data;
        // a new limit takes effect at once only while hunting
        if (phase == PhHunt) hunt_left = data;
      end
      default: ;
    endcase
  endfunction

  function void close_attempt(logic [slxf_pkg::StatusW-1:0] status);
    slxf_pkg::result_t r;
    r.result_kind  = slxf_pkg::KindStatus;
    r.payload_byte = '0;
    r.byte_index   = '0;
    r.frame_status = status;
    r.frame_end    = 1'b1;
    owed_results.push_back(r);
    phase     = PhHunt;
    hunt_left = hunt_limit;
  endfunction

  function void take_byte(logic [7:0] b);
    slxf_pkg::result_t r;
    case (phase)
      PhSync2: begin
        // a wrong second sync byte is consumed, never rechecked as a first sync
        if (b != second_sync) close_attempt(slxf_pkg::StatusBadSync2);
        else phase = PhLen;
      end
      PhLen: begin
        if (b == 8'd0) begin
          close_attempt(slxf_pkg::StatusZeroLen);
        end else begin
          frame_len   = b;
          xor_sum     = b;
          payload_cnt = '0;
          phase       = PhData;
        end
      end
      PhData: begin
        r.result_kind  = slxf_pkg::KindPayload;
        r.payload_byte = b;
        r.byte_index   = payload_cnt;
        r.frame_status = '0;
        r.frame_end    = 1'b0;
        owed_results.push_back(r);
        xor_sum     = xor_sum ^ b;
        payload_cnt = payload_cnt + 8'd1;
        if (payload_cnt == frame_len) phase = PhCheck;
      end
      PhCheck: begin
        close_attempt((b == xor_sum) ? slxf_pkg::StatusOk : slxf_pkg::StatusBadSum);
      end
      default: begin
        if (b == first_sync) begin
          phase = PhSync2;
        end else begin
          phase = PhHunt;
          // decrement before test, so a limit of zero wraps to 256 bytes
          hunt_left = hunt_left - 8'd1;
          if (hunt_left == 8'd0) close_attempt(slxf_pkg::StatusNoStart);
        end
      end
    endcase
  endfunction

  function void compare_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      errors++;
      $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, want, got);
    end
  endfunction

  function void match_result(slxf_pkg::result_t got);
    slxf_pkg::result_t want;
    if (owed_results.size() == 0) begin
      errors++;
      $display("%0t: unexpected result, expected none, actual 0x%0h", $time, got);
      return;
    end
    want = owed_results.pop_front();
    compare_field("result_kind", want.result_kind, got.result_kind);
    compare_field("payload_byte", want.payload_byte, got.payload_byte);
    compare_field("byte_index", want.byte_index, got.byte_index);
    compare_field("frame_status", want.frame_status, got.frame_status);
    compare_field("frame_end", want.frame_end, got.frame_end);
    if (got.result_kind == slxf_pkg::KindStatus) status_seen[got.frame_status]++;
    else payloads_seen++;
  endfunction
endclass

module tb_sync_length_xor_frame_receiver_top;
  import slxf_pkg::*;

  localparam logic [CfgIndexW-1:0] RegSpare = 2'd3;
  localparam int PhaseBytes = 130;

  logic                 clk;
  logic                 rst;
  logic                 push;
  logic                 full;
  logic [ByteW-1:0]     rx_byte;
  logic                 empty;
  logic                 pop = 1'b0;
  logic                 result_kind;
  logic [ByteW-1:0]     payload_byte;
  logic [ByteW-1:0]     byte_index;
  logic [StatusW-1:0]   frame_status;
  logic                 frame_end;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CfgIndexW-1:0] cfg_index;
  logic [ByteW-1:0]     cfg_data;

  bit calm;
  int pop_hold;
  int bytes_sent;
  int settings_used;
  frame_result_book book = new();

  sync_length_xor_frame_receiver_top u_dut (
    .clk          (clk),
    .rst          (rst),
    .push         (push),
    .full         (full),
    .rx_byte      (rx_byte),
    .empty        (empty),
    .pop          (pop),
    .result_kind  (result_kind),
    .payload_byte (payload_byte),
    .byte_index   (byte_index),
    .frame_status (frame_status),
    .frame_end    (frame_end),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("Mismatches found");
    $finish;
  end

  // mostly short gaps, a few long ones, none during calm stretches
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (calm) return 0;
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic logic [7:0] other_than(logic [7:0] v);
    return v ^ 8'($urandom_range(1, 255));
  endfunction

  function automatic logic [7:0] pick_len();
    if ($urandom_range(0, 29) == 0) return 8'($urandom_range(1, 255));
    return 8'($urandom_range(1, 10));
  endfunction

  // result side: check every popped result, stall pop at random
  always @(posedge clk) begin
    if (rst) begin
      pop <= 1'b0;
      pop_hold = 0;
    end else begin
      if (pop && !empty)
        book.match_result({result_kind, payload_byte, byte_index, frame_status, frame_end});
      if (pop_hold > 0) begin
        pop <= 1'b0;
        pop_hold--;
      end else begin
        pop <= 1'b1;
        if ($urandom_range(0, 5) == 0) pop_hold = pick_gap();
      end
    end
  end

  task automatic send_byte(input logic [7:0] b);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    push    <= 1'b1;
    rx_byte <= b;
    @(posedge clk);
    while (full) @(posedge clk);
    book.take_byte(b);
    bytes_sent++;
  endtask

  // wait until every owed result is out and the parser has gone quiet
  task automatic settle();
    push <= 1'b0;
    while (book.owed_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // leaves cfg_valid high so back-to-back writes need no extra assignment
  task automatic write_reg(input logic [CfgIndexW-1:0] idx, input logic [7:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    book.write_reg(idx, data);
  endtask

  task automatic apply_setting(input logic [7:0] s1, input logic [7:0] s2,
                               input logic [7:0] lim);
    write_reg(RegFirstSync, s1);
    write_reg(RegSecondSync, s2);
    write_reg(RegHuntLimit, lim);
    cfg_valid <= 1'b0;
    settings_used++;
  endtask

  task automatic send_frame(input logic [7:0] len, input bit good_sum);
    logic [7:0] sum;
    logic [7:0] b;
    send_byte(book.first_sync);
    send_byte(book.second_sync);
    send_byte(len);
    sum = len;
    for (int i = 0; i < len; i++) begin
      b = 8'($urandom);
      send_byte(b);
      sum = sum ^ b;
    end
    if (!good_sum) sum = other_than(sum);
    send_byte(sum);
  endtask

  task automatic random_traffic(input int count);
    int stop;
    int kind;
    int n;
    stop = bytes_sent + count;
    while (bytes_sent < stop) begin
      if ($urandom_range(0, 29) == 0) calm = !calm;
      kind = $urandom_range(0, 99);
      if (kind < 60) begin
        send_frame(pick_len(), 1'b1);
      end else if (kind < 70) begin
        send_frame(pick_len(), 1'b0);
      end else if (kind < 78) begin
        n = $urandom_range(1, 24);
        repeat (n) send_byte(8'($urandom));
      end else if (kind < 86) begin
        send_byte(book.first_sync);
        send_byte(other_than(book.second_sync));
      end else if (kind < 93) begin
        send_byte(book.first_sync);
        send_byte(book.second_sync);
        send_byte(8'd0);
      end else begin
        // first sync followed by whatever comes
        send_byte(book.first_sync);
        send_byte(8'($urandom));
      end
    end
  endtask

  initial begin
    logic [7:0] opening [26];
    logic [7:0] s1;
    int waited;
    int failures;

    opening = '{
      8'h06, 8'h85, 8'h01, 8'hFF, 8'hFE,          // good one-byte frame
      8'h06, 8'h85, 8'h00,                        // zero length
      8'h06, 8'h06,                               // first sync where second belongs
      8'h06, 8'h85, 8'h02, 8'h00, 8'h80, 8'h83,   // checksum off by one bit
      8'h00, 8'hFF, 8'h85, 8'h01, 8'h02,          // ten bytes with no start
      8'h03, 8'h04, 8'h05, 8'h07, 8'h80
    };
    rst       = 1'b1;
    push      = 1'b0;
    rx_byte   = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    calm      = 1'b0;
    pop_hold  = 0;
    bytes_sent    = 0;
    settings_used = 1;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    foreach (opening[i]) send_byte(opening[i]);
    random_traffic(PhaseBytes);

    // leave a frame open across the register writes
    send_byte(book.first_sync);
    send_byte(book.second_sync);
    send_byte(8'd3);
    settle();
    write_reg(RegSpare, 8'($urandom));
    apply_setting(8'h00, 8'hFF, 8'd1);
    send_byte(8'h11);
    send_byte(8'h22);
    send_byte(8'h33);
    send_byte(8'h03);
    random_traffic(PhaseBytes);

    settle();
    apply_setting(8'hFF, 8'h00, 8'd255);
    random_traffic(PhaseBytes);

    // limit of zero wraps: 256 non-sync bytes before the no-start status
    settle();
    s1 = 8'($urandom);
    apply_setting(s1, 8'($urandom), 8'd0);
    repeat (256) send_byte(other_than(s1));
    random_traffic(PhaseBytes);

    settle();
    apply_setting(8'h06, 8'h06, 8'd3);
    random_traffic(PhaseBytes);

    settle();
    apply_setting(8'($urandom), 8'($urandom), 8'($urandom_range(1, 255)));
    random_traffic(PhaseBytes);

    push <= 1'b0;
    waited = 0;
    while (book.owed_results.size() != 0 && waited < 20000) begin
      @(posedge clk);
      waited++;
    end
    repeat (4) @(posedge clk);

    failures = book.errors + book.owed_results.size();
    if (book.owed_results.size() != 0)
      $display("%0t: %0d expected results never arrived", $time, book.owed_results.size());
    $display("sent %0d bytes under %0d register settings; checked %0d payload bytes",
             bytes_sent, settings_used, book.payloads_seen);
    $display("frame statuses: ok %0d, no start %0d, bad second sync %0d, zero length %0d, bad checksum %0d",
             book.status_seen[StatusOk], book.status_seen[StatusNoStart],
             book.status_seen[StatusBadSync2], book.status_seen[StatusZeroLen],
             book.status_seen[StatusBadSum]);
    if (failures == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
